FILE: rtl/core/alpha_run_length_record_decoder_macros.svh
// Assertion macros shared by the alpha run-length record decoder modules.
`ifndef ALPHA_RUN_LENGTH_RECORD_DECODER_MACROS_SVH
`define ALPHA_RUN_LENGTH_RECORD_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define ARLRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arlrd same-cycle check failed");
`define ARLRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arlrd next-cycle check failed");
`else
`define ARLRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ARLRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/arlrd_pkg.sv
// Shared types, constants and helpers of the alpha run-length record decoder.
`timescale 1ns / 1ps
`default_nettype none
package arlrd_pkg;

    localparam int DIM_BITS     = 16;
    localparam int HDR_BYTES    = 24;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [4:0] HDR_LAST = 5'(HDR_BYTES - 1);
    localparam logic [4:0] HDR_DONE = 5'(HDR_BYTES);
    localparam logic [15:0] DIM_MASK = 16'(((64'd1 << DIM_BITS) - 64'd1));

    localparam logic [7:0] MAGIC_0 = 8'h56;
    localparam logic [7:0] MAGIC_1 = 8'h46;
    localparam logic [7:0] MAGIC_2 = 8'h41;
    localparam logic [7:0] MAGIC_3 = 8'h52;
    localparam logic [7:0] VERSION = 8'h01;
    localparam logic [7:0] COUNT_MASK = 8'h7f;
    localparam logic [7:0] REPEAT_BIT = 8'h80;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_DECODED_LIMIT = 2'd2
    } arlrd_cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_PIXEL_RUN = 2'd0,
        KIND_FINISHED  = 2'd1,
        KIND_FAILED    = 2'd2
    } arlrd_kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_HEADER     = 3'd1,
        ST_LAYOUT     = 3'd2,
        ST_LIMIT      = 3'd3,
        ST_RAW_LENGTH = 3'd4,
        ST_OVERFLOW   = 3'd5,
        ST_TRUNCATED  = 3'd6,
        ST_TRAILING   = 3'd7
    } arlrd_status_t;

    // One command from the front end: an optional pixel run, then an
    // optional closing status.
    typedef struct packed {
        logic          has_pixel;
        logic [7:0]    pixel_value;
        logic [7:0]    run_length;
        logic          has_status;
        logic          status_fail;
        arlrd_status_t status_code;
    } arlrd_cmd_t;

    function automatic logic [15:0] dim_value(input logic [15:0] cfg_dim);
        return cfg_dim & DIM_MASK;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/arlrd_if.sv
// Handshake interfaces of the decoder: encoded bytes, results and configuration writes.
`timescale 1ns / 1ps
`default_nettype none
interface arlrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_record;
    modport source (output valid, output data_byte, output end_of_record, input ready);
    modport sink   (input valid, input data_byte, input end_of_record, output ready);
endinterface

interface arlrd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] pixel_value;
    logic [7:0] run_length;
    logic [2:0] status_code;
    logic       last_result;
    modport source (output valid, output result_kind, output pixel_value,
                    output run_length, output status_code, output last_result,
                    input ready);
    modport sink   (input valid, input result_kind, input pixel_value,
                    input run_length, input status_code, input last_result,
                    output ready);
endinterface

interface arlrd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/arlrd_front.sv
// Front end: configuration registers, header checks and per-byte run decoding.
`timescale 1ns / 1ps
`default_nettype none
`include "alpha_run_length_record_decoder_macros.svh"
module arlrd_front
    import arlrd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    arlrd_in_if.sink    enc,
    arlrd_cfg_if.sink   cfg,
    input  wire logic   q_ready,
    output logic        q_push,
    output arlrd_cmd_t  q_cmd
);

    logic [15:0] width_reg, height_reg;
    logic [31:0] limit_reg;
    logic [31:0] product_reg;

    logic [4:0]  hdr_pos_reg, hdr_pos_next;
    logic [1:0]  hdr_fault_reg, hdr_fault_next;
    logic        area_hi_nz_reg, area_hi_nz_next;
    logic [31:0] area_lo_reg, area_lo_next;
    logic        run_mode_reg, run_mode_next;
    logic [31:0] remain_reg, remain_next;
    logic [7:0]  lit_rem_reg, lit_rem_next;
    logic        rep_pend_reg, rep_pend_next;
    logic [7:0]  rep_len_reg, rep_len_next;
    logic        failed_reg, failed_next;

    logic          fire;
    logic [7:0]    b;
    logic          eor;
    logic [31:0]   dim_word;
    logic [7:0]    dim_byte;
    logic [31:0]   area_full;
    logic [7:0]    run;
    logic          fail_now;
    arlrd_status_t fail_code;
    logic          close_ok;
    arlrd_cmd_t    cmd;

    assign cfg.ready = 1'b1;
    assign enc.ready = q_ready;
    assign fire      = enc.valid & q_ready;
    assign b         = enc.data_byte;
    assign eor       = enc.end_of_record;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            limit_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_FRAME_WIDTH:   width_reg  <= cfg.data[15:0];
                CFG_FRAME_HEIGHT:  height_reg <= cfg.data[15:0];
                CFG_DECODED_LIMIT: limit_reg  <= cfg.data;
                default:           ;
            endcase
        end
    end

    // The expected area is settled long before the last header byte arrives.
    always_ff @(posedge clk)
    begin
        product_reg <= dim_value(width_reg) * dim_value(height_reg);
    end

    always_comb
    begin
        dim_word = (hdr_pos_reg < 5'd12) ? {16'd0, dim_value(width_reg)}
                                         : {16'd0, dim_value(height_reg)};
        case (hdr_pos_reg[1:0])
            2'd0:    dim_byte = dim_word[31:24];
            2'd1:    dim_byte = dim_word[23:16];
            2'd2:    dim_byte = dim_word[15:8];
            default: dim_byte = dim_word[7:0];
        endcase
    end

    assign area_full = {area_lo_reg[23:0], b};
    assign run       = {1'b0, b[6:0] & COUNT_MASK[6:0]} + 8'd1;

    always_comb
    begin
        hdr_pos_next    = hdr_pos_reg;
        hdr_fault_next  = hdr_fault_reg;
        area_hi_nz_next = area_hi_nz_reg;
        area_lo_next    = area_lo_reg;
        run_mode_next   = run_mode_reg;
        remain_next     = remain_reg;
        lit_rem_next    = lit_rem_reg;
        rep_pend_next   = rep_pend_reg;
        rep_len_next    = rep_len_reg;
        failed_next     = failed_reg;
        fail_now        = 1'b0;
        fail_code       = ST_OK;
        close_ok        = 1'b0;
        cmd             = '0;

        if (failed_reg)
        begin
            // Bytes after a failure are dropped up to the end of the record.
        end
        else if (hdr_pos_reg < HDR_DONE)
        begin
            hdr_pos_next = hdr_pos_reg + 5'd1;
            area_lo_next = area_full;
            if (hdr_pos_reg < 5'd4)
            begin
                case (hdr_pos_reg[1:0])
                    2'd0:    if (b != MAGIC_0 && hdr_fault_next == 2'd0) hdr_fault_next = 2'd1;
                    2'd1:    if (b != MAGIC_1 && hdr_fault_next == 2'd0) hdr_fault_next = 2'd1;
                    2'd2:    if (b != MAGIC_2 && hdr_fault_next == 2'd0) hdr_fault_next = 2'd1;
                    default: if (b != MAGIC_3 && hdr_fault_next == 2'd0) hdr_fault_next = 2'd1;
                endcase
            end
            else if (hdr_pos_reg == 5'd4)
            begin
                if (b != VERSION && hdr_fault_next == 2'd0)
                    hdr_fault_next = 2'd1;
            end
            else if (hdr_pos_reg == 5'd5)
            begin
                if (b > 8'd1 && hdr_fault_next == 2'd0)
                    hdr_fault_next = 2'd2;
                run_mode_next = b[0];
            end
            else if (hdr_pos_reg < 5'd8)
            begin
                if (b != 8'd0 && hdr_fault_next == 2'd0)
                    hdr_fault_next = 2'd2;
            end
            else if (hdr_pos_reg < 5'd16)
            begin
                if (dim_byte != b && hdr_fault_next == 2'd0)
                    hdr_fault_next = 2'd2;
            end
            else if (hdr_pos_reg < 5'd20)
            begin
                // Upper half of the 64-bit area must be zero to match.
                if (b != 8'd0)
                    area_hi_nz_next = 1'b1;
            end

            if (hdr_pos_reg != HDR_LAST)
            begin
                if (eor)
                begin
                    fail_now  = 1'b1;
                    fail_code = ST_HEADER;
                end
            end
            else
            begin
                if (hdr_fault_next == 2'd0 &&
                    (product_reg == 32'd0 || product_reg > limit_reg ||
                     area_hi_nz_next || area_full != product_reg))
                    hdr_fault_next = 2'd3;
                remain_next = area_full;
                if (hdr_fault_next != 2'd0)
                begin
                    fail_now  = 1'b1;
                    fail_code = arlrd_status_t'({1'b0, hdr_fault_next});
                end
            end
        end
        else if (!run_mode_reg)
        begin
            if (remain_reg == 32'd0)
            begin
                fail_now  = 1'b1;
                fail_code = ST_RAW_LENGTH;
            end
            else
            begin
                cmd.has_pixel   = 1'b1;
                cmd.pixel_value = b;
                cmd.run_length  = 8'd1;
                remain_next     = remain_reg - 32'd1;
            end
        end
        else if (rep_pend_reg)
        begin
            cmd.has_pixel   = 1'b1;
            cmd.pixel_value = b;
            cmd.run_length  = rep_len_reg;
            remain_next     = remain_reg - {24'd0, rep_len_reg};
            rep_pend_next   = 1'b0;
        end
        else if (lit_rem_reg != 8'd0)
        begin
            cmd.has_pixel   = 1'b1;
            cmd.pixel_value = b;
            cmd.run_length  = 8'd1;
            remain_next     = remain_reg - 32'd1;
            lit_rem_next    = lit_rem_reg - 8'd1;
        end
        else
        begin
            // Control byte: the run must fit in the pixels still missing.
            if (remain_reg == 32'd0)
            begin
                fail_now  = 1'b1;
                fail_code = ST_TRAILING;
            end
            else if ({24'd0, run} > remain_reg)
            begin
                fail_now  = 1'b1;
                fail_code = ST_OVERFLOW;
            end
            else if ((b & REPEAT_BIT) != 8'd0)
            begin
                rep_pend_next = 1'b1;
                rep_len_next  = run;
            end
            else
            begin
                lit_rem_next = run;
            end
        end

        if (!failed_reg && !fail_now && eor)
        begin
            if (!run_mode_next)
            begin
                if (remain_next != 32'd0)
                begin
                    fail_now  = 1'b1;
                    fail_code = ST_RAW_LENGTH;
                end
            end
            else if (rep_pend_next || lit_rem_next != 8'd0)
            begin
                fail_now  = 1'b1;
                fail_code = ST_TRUNCATED;
            end
            else if (remain_next != 32'd0)
            begin
                fail_now  = 1'b1;
                fail_code = ST_TRAILING;
            end
            if (!fail_now)
                close_ok = 1'b1;
        end

        if (fail_now)
        begin
            cmd.has_status  = 1'b1;
            cmd.status_fail = 1'b1;
            cmd.status_code = fail_code;
            failed_next     = 1'b1;
        end
        else if (close_ok)
        begin
            cmd.has_status  = 1'b1;
            cmd.status_code = ST_OK;
        end

        if (eor && (failed_reg || fail_now || close_ok))
        begin
            hdr_pos_next    = '0;
            hdr_fault_next  = '0;
            area_hi_nz_next = 1'b0;
            area_lo_next    = '0;
            run_mode_next   = 1'b0;
            remain_next     = '0;
            lit_rem_next    = '0;
            rep_pend_next   = 1'b0;
            rep_len_next    = '0;
            failed_next     = 1'b0;
        end
    end

    assign q_cmd  = cmd;
    assign q_push = fire & (cmd.has_pixel | cmd.has_status);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg    <= '0;
            hdr_fault_reg  <= '0;
            area_hi_nz_reg <= 1'b0;
            area_lo_reg    <= '0;
            run_mode_reg   <= 1'b0;
            remain_reg     <= '0;
            lit_rem_reg    <= '0;
            rep_pend_reg   <= 1'b0;
            rep_len_reg    <= '0;
            failed_reg     <= 1'b0;
        end
        else if (fire)
        begin
            hdr_pos_reg    <= hdr_pos_next;
            hdr_fault_reg  <= hdr_fault_next;
            area_hi_nz_reg <= area_hi_nz_next;
            area_lo_reg    <= area_lo_next;
            run_mode_reg   <= run_mode_next;
            remain_reg     <= remain_next;
            lit_rem_reg    <= lit_rem_next;
            rep_pend_reg   <= rep_pend_next;
            rep_len_reg    <= rep_len_next;
            failed_reg     <= failed_next;
        end
    end

    `ARLRD_ASSERT_NOW(a_failed_after_header, clk, rst_n, failed_reg, (hdr_pos_reg == HDR_DONE))
    `ARLRD_ASSERT_NOW(a_owed_only_in_rle, clk, rst_n, (lit_rem_reg != 8'd0) || rep_pend_reg, (run_mode_reg && hdr_pos_reg == HDR_DONE))

endmodule
`default_nettype wire

FILE: rtl/core/arlrd_queue.sv
// Short command queue between the front end and the result sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "alpha_run_length_record_decoder_macros.svh"
module arlrd_queue
    import arlrd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire arlrd_cmd_t push_cmd,
    output logic            push_ready,
    output logic            head_valid,
    output arlrd_cmd_t      head_cmd,
    input  wire logic       pop
);

    arlrd_cmd_t           mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 do_pop;

    assign push_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_pop     = pop & head_valid;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    `ARLRD_ASSERT_NOW(a_count_bounded, clk, rst_n, 1'b1, (count_reg <= QCNT_BITS'(QUEUE_DEPTH)))
    `ARLRD_ASSERT_NOW(a_no_push_when_full, clk, rst_n, push, push_ready)

endmodule
`default_nettype wire

FILE: rtl/core/arlrd_back.sv
// Result sequencer: expands each command into its pixel run and status items.
`timescale 1ns / 1ps
`default_nettype none
`include "alpha_run_length_record_decoder_macros.svh"
module arlrd_back
    import arlrd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       head_valid,
    input  wire arlrd_cmd_t head_cmd,
    output logic            pop,
    arlrd_out_if.source     dec
);

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  pixel_reg;
    logic [7:0]  run_reg;
    logic [2:0]  code_reg;
    logic        last_reg;
    logic        phase_reg, phase_next;
    logic        load;
    logic        emit_pixel;

    // The output register takes a new item when it is empty or being drained.
    assign load       = head_valid & (~out_valid_reg | dec.ready);
    assign emit_pixel = head_cmd.has_pixel & ~phase_reg;

    always_comb
    begin
        phase_next = phase_reg;
        pop        = 1'b0;
        if (load)
        begin
            if (emit_pixel && head_cmd.has_status)
                phase_next = 1'b1;
            else
            begin
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (dec.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (emit_pixel)
            begin
                kind_reg  <= KIND_PIXEL_RUN;
                pixel_reg <= head_cmd.pixel_value;
                run_reg   <= head_cmd.run_length;
                code_reg  <= ST_OK;
                last_reg  <= 1'b0;
            end
            else
            begin
                kind_reg  <= head_cmd.status_fail ? KIND_FAILED : KIND_FINISHED;
                pixel_reg <= '0;
                run_reg   <= '0;
                code_reg  <= head_cmd.status_code;
                last_reg  <= 1'b1;
            end
        end
    end

    assign dec.valid       = out_valid_reg;
    assign dec.result_kind = kind_reg;
    assign dec.pixel_value = pixel_reg;
    assign dec.run_length  = run_reg;
    assign dec.status_code = code_reg;
    assign dec.last_result = last_reg;

    `ARLRD_ASSERT_NOW(a_status_pending_has_head, clk, rst_n, phase_reg, (head_valid && head_cmd.has_status))
    `ARLRD_ASSERT_NEXT(a_status_follows_pixel, clk, rst_n, (load && emit_pixel && head_cmd.has_status), phase_reg)

endmodule
`default_nettype wire

FILE: rtl/core/alpha_run_length_record_decoder.sv
// Top level of the alpha run-length record decoder.
//
//  Channel | Role        | Contents
//  --------+-------------+------------------------------------------------------
//  enc     | item in     | data_byte, end_of_record
//  dec     | item out    | result_kind, pixel_value, run_length, status_code,
//          |             | last_result
//  cfg     | write in    | index (0 width, 1 height, 2 decoded limit), data
//
// The front end takes one encoded byte per cycle while the command queue has
// room, with counter updates and compares in the front end's state registers.
// An item yields at most two results (a pixel run and a closing status); the
// result sequencer sends one result per cycle while the receiver is ready, and
// the four-entry command queue absorbs the items that yield two results.
// An accepted byte's first result passes through the queue and output register.
// Reset is asynchronous and active low and clears all control state; no
// clearing pass is needed. A stalled output holds its item while the front end
// keeps accepting bytes until the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module alpha_run_length_record_decoder
    import arlrd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    arlrd_in_if.sink    enc,
    arlrd_out_if.source dec,
    arlrd_cfg_if.sink   cfg
);

    logic       q_push;
    logic       q_ready;
    arlrd_cmd_t q_cmd;
    logic       head_valid;
    arlrd_cmd_t head_cmd;
    logic       pop;

    // Front end: registers, header validation and per-byte decode. It emits
    // one command per byte that produces any result.
    arlrd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .enc     (enc),
        .cfg     (cfg),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    // The queue lets the front end run ahead while results are stalled.
    arlrd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .push_ready (q_ready),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    // The back end turns each command into one or two result items.
    arlrd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .dec        (dec)
    );

endmodule
`default_nettype wire

FILE: bench/arlrd_result_check.sv
// Result checker for the alpha run-length record decoder: predicts every result and compares.
`timescale 1ns / 1ps
module arlrd_result_check
    import arlrd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    arlrd_in_if  enc,
    arlrd_out_if dec,
    arlrd_cfg_if cfg,
    output int   errors,
    output int   pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        arlrd_kind_t   kind;
        logic [7:0]    value;
        logic [7:0]    len;
        arlrd_status_t code;
        logic          last;
    } dec_result_t;

    dec_result_t expected_results[$];

    // Register copies as seen by the decoder.
    logic [15:0] exp_width  = '0;
    logic [15:0] exp_height = '0;
    logic [31:0] pix_limit  = '0;

    // Per-record decode state.
    int            hdr_count = 0;
    arlrd_status_t hdr_err   = ST_OK;
    logic [63:0]   area_decl = '0;
    logic          rle_mode  = 1'b0;
    logic [63:0]   pix_done  = '0;
    logic [7:0]    lit_left  = '0;
    logic          rep_wait  = 1'b0;
    logic [7:0]    rep_len   = '0;
    logic          rec_dead  = 1'b0;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task clear_record();
        hdr_count = 0;
        hdr_err   = ST_OK;
        area_decl = '0;
        rle_mode  = 1'b0;
        pix_done  = '0;
        lit_left  = '0;
        rep_wait  = 1'b0;
        rep_len   = '0;
        rec_dead  = 1'b0;
    endtask

    task push_result(input arlrd_kind_t k, input logic [7:0] v, input logic [7:0] n,
                     input arlrd_status_t c, input logic l);
        dec_result_t r;
        r.kind  = k;
        r.value = v;
        r.len   = n;
        r.code  = c;
        r.last  = l;
        expected_results.insert(expected_results.size(), r);
    endtask

    // A failure closes the record at once; the rest of it is skipped up to its end.
    task fail_record(input arlrd_status_t c, input logic eor);
        push_result(KIND_FAILED, 8'd0, 8'd0, c, 1'b1);
        if (eor)
            clear_record();
        else
            rec_dead = 1'b1;
    endtask

    task note_fault(input arlrd_status_t c);
        if (hdr_err == ST_OK)
            hdr_err = c;
    endtask

    task predict_byte(input logic [7:0] b, input logic eor);
        logic [31:0]   dim;
        logic [7:0]    magic;
        logic [63:0]   w64;
        logic [63:0]   h64;
        logic [63:0]   area;
        logic [7:0]    run;
        arlrd_status_t close_code;
        if (rec_dead)
        begin
            if (eor)
                clear_record();
            return;
        end
        if (hdr_count < HDR_BYTES)
        begin
            if (hdr_count < 4)
            begin
                magic = (hdr_count == 0) ? MAGIC_0 : (hdr_count == 1) ? MAGIC_1 :
                        (hdr_count == 2) ? MAGIC_2 : MAGIC_3;
                if (b != magic)
                    note_fault(ST_HEADER);
            end
            else if (hdr_count == 4)
            begin
                if (b != VERSION)
                    note_fault(ST_HEADER);
            end
            else if (hdr_count == 5)
            begin
                if (b > 8'd1)
                    note_fault(ST_LAYOUT);
                rle_mode = b[0];
            end
            else if (hdr_count < 8)
            begin
                if (b != 8'd0)
                    note_fault(ST_LAYOUT);
            end
            else if (hdr_count < 16)
            begin
                dim = (hdr_count < 12) ? {16'd0, exp_width & DIM_MASK}
                                       : {16'd0, exp_height & DIM_MASK};
                if (8'(dim >> (8 * (3 - (hdr_count % 4)))) != b)
                    note_fault(ST_LAYOUT);
            end
            else
            begin
                area_decl = {area_decl[55:0], b};
            end
            hdr_count++;
            if (hdr_count < HDR_BYTES)
            begin
                if (eor)
                    fail_record(ST_HEADER, 1'b1);
                return;
            end
            if (hdr_err == ST_OK)
            begin
                w64  = 64'(exp_width & DIM_MASK);
                h64  = 64'(exp_height & DIM_MASK);
                area = w64 * h64;
                if (w64 == 0 || h64 == 0 || area > 64'(pix_limit) || area_decl != area)
                    hdr_err = ST_LIMIT;
            end
            if (hdr_err != ST_OK)
            begin
                fail_record(hdr_err, eor);
                return;
            end
        end
        else if (!rle_mode)
        begin
            if (pix_done >= area_decl)
            begin
                fail_record(ST_RAW_LENGTH, eor);
                return;
            end
            push_result(KIND_PIXEL_RUN, b, 8'd1, ST_OK, 1'b0);
            pix_done++;
        end
        else if (rep_wait)
        begin
            push_result(KIND_PIXEL_RUN, b, rep_len, ST_OK, 1'b0);
            pix_done += 64'(rep_len);
            rep_wait = 1'b0;
        end
        else if (lit_left > 0)
        begin
            push_result(KIND_PIXEL_RUN, b, 8'd1, ST_OK, 1'b0);
            pix_done++;
            lit_left--;
        end
        else
        begin
            run = (b & COUNT_MASK) + 8'd1;
            if (pix_done >= area_decl)
            begin
                fail_record(ST_TRAILING, eor);
                return;
            end
            if (64'(run) > area_decl - pix_done)
            begin
                fail_record(ST_OVERFLOW, eor);
                return;
            end
            if ((b & REPEAT_BIT) != 8'd0)
            begin
                rep_wait = 1'b1;
                rep_len  = run;
            end
            else
            begin
                lit_left = run;
            end
        end
        if (eor)
        begin
            if (!rle_mode)
                close_code = (pix_done != area_decl) ? ST_RAW_LENGTH : ST_OK;
            else if (rep_wait || lit_left > 0)
                close_code = ST_TRUNCATED;
            else
                close_code = (pix_done != area_decl) ? ST_TRAILING : ST_OK;
            if (close_code != ST_OK)
            begin
                fail_record(close_code, 1'b1);
                return;
            end
            push_result(KIND_FINISHED, 8'd0, 8'd0, ST_OK, 1'b1);
            clear_record();
        end
    endtask

    always @(posedge clk)
    begin : watch
        dec_result_t want;
        dec_result_t got;
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_FRAME_WIDTH:   exp_width  = cfg.data[15:0];
                    CFG_FRAME_HEIGHT:  exp_height = cfg.data[15:0];
                    CFG_DECODED_LIMIT: pix_limit  = cfg.data;
                    default:           ;
                endcase
            end
            if (enc.valid && enc.ready)
                predict_byte(enc.data_byte, enc.end_of_record);
            if (dec.valid && dec.ready)
            begin
                got.kind  = arlrd_kind_t'(dec.result_kind);
                got.value = dec.pixel_value;
                got.len   = dec.run_length;
                got.code  = arlrd_status_t'(dec.status_code);
                got.last  = dec.last_result;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display({"unexpected result: kind=%0d value=%0d run=%0d",
                                  " status=%0d last=%0d"},
                                 got.kind, got.value, got.len, got.code, got.last);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.value !== want.value ||
                        got.len !== want.len || got.code !== want.code ||
                        got.last !== want.last)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"mismatch: expected kind=%0d value=%0d run=%0d",
                                      " status=%0d last=%0d, got kind=%0d value=%0d",
                                      " run=%0d status=%0d last=%0d"},
                                     want.kind, want.value, want.len, want.code,
                                     want.last, got.kind, got.value, got.len,
                                     got.code, got.last);
                    end
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

FILE: bench/tb_alpha_run_length_record_decoder.sv
// Testbench top for the alpha run-length record decoder: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_alpha_run_length_record_decoder;
    import arlrd_pkg::*;

    // Number of encoded bytes after which the random part stops, and the point
    // from which neither side idles any more.
    localparam int TARGET_ITEMS  = 1900;
    localparam int QUIET_AFTER   = 1700;
    // Bytes per configuration phase in the random part.
    localparam int PHASE_ITEMS   = 160;
    // Cycles allowed after the last result before registers change; a byte passes
    // the command queue and output register on its way out, so this is ample.
    localparam int SETTLE_CYCLES = 8;
    // Length of the one long receiver stall that fills the command queue.
    localparam int LONG_STALL    = 300;

    // Index that maps to no register; the decoder must ignore writes to it.
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam logic [7:0] MODE_RAW   = 8'd0;
    localparam logic [7:0] MODE_RLE   = 8'd1;
    localparam logic [7:0] MODE_BAD   = 8'd3;

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic quiet    = 1'b0;
    logic hold_req = 1'b0;

    int items_sent = 0;
    int err_count;
    int pend_count;

    // Record under construction, sent byte by byte with the end flag on its
    // last byte.
    logic [7:0]  rec[$];
    // Frame size as currently programmed, used to build matching headers.
    logic [31:0] cur_w = '0;
    logic [31:0] cur_h = '0;

    arlrd_in_if  enc_if();
    arlrd_out_if dec_if();
    arlrd_cfg_if cfg_if();

    alpha_run_length_record_decoder u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .enc   (enc_if),
        .dec   (dec_if),
        .cfg   (cfg_if)
    );

    arlrd_result_check u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .enc     (enc_if),
        .dec     (dec_if),
        .cfg     (cfg_if),
        .errors  (err_count),
        .pending (pend_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one byte and hold it until the decoder takes it. The ready seen
    // right after the edge is the value the decoder sampled at that edge.
    // After acceptance the sender sometimes goes idle for a short burst.
    task send_byte(input logic [7:0] b, input logic eor);
        enc_if.valid         <= 1'b1;
        enc_if.data_byte     <= b;
        enc_if.end_of_record <= eor;
        do @(posedge clk); while (!enc_if.ready);
        items_sent++;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            enc_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task send_record();
        int i;
        for (i = 0; i < rec.size(); i++)
            send_byte(rec[i], i == rec.size() - 1);
        rec.delete();
    endtask

    // Stop sending and wait until every predicted result has come out. The
    // count is read at the falling edge, after the checker has updated it.
    task wait_drained();
        enc_if.valid <= 1'b0;
        @(negedge clk);
        while (pend_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; valid stays high so that writes can follow back to back.
    task write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
    endtask

    // Program all three registers, sometimes with a stray write to the unused
    // index first. Only the low 16 bits of the size registers count.
    task configure(input logic [31:0] w, input logic [31:0] h, input logic [31:0] lim);
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_UNUSED, $urandom());
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_DECODED_LIMIT, lim);
        cfg_if.valid <= 1'b0;
        cur_w = {16'd0, w[15:0]};
        cur_h = {16'd0, h[15:0]};
    endtask

    // Append one byte to the record under construction.
    task put_byte(input logic [7:0] b);
        rec.insert(rec.size(), b);
    endtask

    // The 24-byte header: magic, version, mode, two pad bytes, then width,
    // height and area, all big-endian.
    task put_header(input logic [7:0] mode, input logic [31:0] w, input logic [31:0] h,
                    input logic [63:0] area);
        int i;
        put_byte(MAGIC_0);
        put_byte(MAGIC_1);
        put_byte(MAGIC_2);
        put_byte(MAGIC_3);
        put_byte(VERSION);
        put_byte(mode);
        put_byte(8'd0);
        put_byte(8'd0);
        for (i = 3; i >= 0; i--)
            put_byte(w[8 * i +: 8]);
        for (i = 3; i >= 0; i--)
            put_byte(h[8 * i +: 8]);
        for (i = 7; i >= 0; i--)
            put_byte(area[8 * i +: 8]);
    endtask

    task put_random(input int n);
        repeat (n) put_byte(8'($urandom()));
    endtask

    // A payload that covers the area exactly. In run-length mode it is a mix
    // of repeat runs and literal runs of random lengths.
    task put_payload(input logic [7:0] mode, input int area);
        int left;
        int n;
        int cap;
        left = area;
        if (mode == MODE_RAW)
        begin
            put_random(area);
            left = 0;
        end
        while (left > 0)
        begin
            cap = (left < 128) ? left : 128;
            n   = $urandom_range(1, cap);
            if ($urandom_range(0, 1) == 1)
            begin
                put_byte(REPEAT_BIT | 8'(n - 1));
                put_random(1);
            end
            else
            begin
                put_byte(8'(n - 1));
                put_random(n);
            end
            left -= n;
        end
    endtask

    // Random record for the current frame size. Most are well formed, some
    // carry one defect, and the rest is byte noise with stray record ends.
    task random_record();
        logic [7:0] mode;
        int         area;
        int         pick;
        int         cut;
        int         len;
        int         i;
        mode = ($urandom_range(0, 1) == 1) ? MODE_RLE : MODE_RAW;
        area = cur_w * cur_h;
        pick = $urandom_range(0, 99);
        if (pick >= 88)
        begin
            len = $urandom_range(1, 40);
            for (i = 0; i < len; i++)
                send_byte(8'($urandom()), i == len - 1 || $urandom_range(0, 15) == 0);
        end
        else
        begin
            put_header(mode, cur_w, cur_h, 64'(area));
            if (pick < 65)
                put_payload(mode, area);
            else
            begin
                case (pick % 4)
                    0:
                    begin
                        // A damaged header byte.
                        put_payload(mode, area);
                        cut = $urandom_range(0, HDR_BYTES - 1);
                        rec[cut] = rec[cut] ^ 8'($urandom_range(1, 255));
                    end
                    1:
                    begin
                        // Bytes beyond the declared area.
                        put_payload(mode, area);
                        put_random($urandom_range(1, 3));
                    end
                    2:
                    begin
                        // A record cut short, now and then inside the header.
                        put_payload(mode, area);
                        if ($urandom_range(0, 3) == 0)
                            cut = $urandom_range(1, rec.size() - 1);
                        else
                            cut = $urandom_range(1, 3);
                        repeat (cut) void'(rec.pop_back());
                    end
                    default:
                    begin
                        // A run count larger than the pixels still missing.
                        if (area < 128)
                        begin
                            put_byte(8'($urandom_range(0, 1) << 7) |
                                     8'($urandom_range(area, 127)));
                            put_random($urandom_range(0, 2));
                        end
                        else
                            put_payload(mode, area);
                    end
                endcase
            end
            send_record();
        end
    endtask

    // New frame size for a random phase: mostly small, sometimes sixteen wide
    // so that full 128-pixel runs fit, now and then a limit below the area.
    // The unused upper bits of the size registers get random values.
    task random_config();
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] lim;
        int          sel;
        int          a;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            w = 32'd16;
            h = $urandom_range(8, 16);
        end
        else
        begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
        end
        a = w * h;
        if (sel == 1)
            lim = a - 1;
        else if (sel == 2)
            lim = 32'hFFFF_FFFF;
        else
            lim = a + $urandom_range(0, 50);
        w[31:16] = 16'($urandom());
        h[31:16] = 16'($urandom());
        configure(w, h, lim);
    endtask

    // Receiver side: ready in random stretches with short stalls, plus one
    // long stall on request while the sender keeps offering bytes.
    initial
    begin : result_sink
        dec_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                dec_if.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                dec_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                dec_if.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int phase_start;
        enc_if.valid         <= 1'b0;
        enc_if.data_byte     <= '0;
        enc_if.end_of_record <= 1'b0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= '0;
        cfg_if.data          <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed records on a 3 by 2 frame whose limit equals the area.
        configure(32'd3, 32'd2, 32'd6);
        // Good raw record with extreme pixel values.
        put_header(MODE_RAW, 32'd3, 32'd2, 64'd6);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h55);
        put_byte(8'hAA);
        put_byte(8'h01);
        put_byte(8'h80);
        send_record();
        // Good run-length record: a repeat of two, then four literals.
        put_header(MODE_RLE, 32'd3, 32'd2, 64'd6);
        put_byte(8'h81);
        put_byte(8'h7F);
        put_byte(8'h03);
        put_random(4);
        send_record();
        // Record that ends inside the header.
        put_header(MODE_RAW, 32'd3, 32'd2, 64'd6);
        repeat (14) void'(rec.pop_back());
        send_record();
        // Wrong magic; the payload that follows is skipped.
        put_header(MODE_RAW, 32'd3, 32'd2, 64'd6);
        rec[0] = 8'h00;
        put_random(6);
        send_record();
        // Wrong version, with the record ending on the last header byte.
        put_header(MODE_RAW, 32'd3, 32'd2, 64'd6);
        rec[4] = 8'h02;
        send_record();
        // Unknown mode.
        put_header(MODE_BAD, 32'd3, 32'd2, 64'd6);
        put_random(6);
        send_record();
        // Nonzero pad byte.
        put_header(MODE_RAW, 32'd3, 32'd2, 64'd6);
        rec[7] = 8'h80;
        put_random(6);
        send_record();
        // Width that differs from the register.
        put_header(MODE_RAW, 32'd4, 32'd2, 64'd6);
        put_random(6);
        send_record();
        // Area that is not width times height.
        put_header(MODE_RAW, 32'd3, 32'd2, 64'd7);
        put_random(7);
        send_record();
        // Raw mode: two bytes too many, then three bytes too few.
        put_header(MODE_RAW, 32'd3, 32'd2, 64'd6);
        put_random(8);
        send_record();
        put_header(MODE_RAW, 32'd3, 32'd2, 64'd6);
        put_random(3);
        send_record();
        // Empty payloads in both modes.
        put_header(MODE_RAW, 32'd3, 32'd2, 64'd6);
        send_record();
        put_header(MODE_RLE, 32'd3, 32'd2, 64'd6);
        send_record();
        // Run count beyond the missing pixels.
        put_header(MODE_RLE, 32'd3, 32'd2, 64'd6);
        put_byte(8'h86);
        put_random(2);
        send_record();
        // Record ends while a repeat value, then literal bytes, are owed.
        put_header(MODE_RLE, 32'd3, 32'd2, 64'd6);
        put_byte(8'h82);
        send_record();
        put_header(MODE_RLE, 32'd3, 32'd2, 64'd6);
        put_byte(8'h02);
        put_random(1);
        send_record();
        // Control byte after the area is full, then a record short of the area.
        put_header(MODE_RLE, 32'd3, 32'd2, 64'd6);
        put_byte(8'h85);
        put_byte(8'h44);
        put_byte(8'h00);
        send_record();
        put_header(MODE_RLE, 32'd3, 32'd2, 64'd6);
        put_byte(8'h81);
        put_byte(8'h55);
        send_record();

        // Limit one below the area: a correct header fails the limit check.
        wait_drained();
        configure(32'd3, 32'd2, 32'd5);
        put_header(MODE_RAW, 32'd3, 32'd2, 64'd6);
        put_random(6);
        send_record();

        // All registers zero: a zero-sized frame is refused.
        wait_drained();
        configure(32'd0, 32'd0, 32'd0);
        put_header(MODE_RAW, 32'd0, 32'd0, 64'd0);
        send_record();

        // Largest frame and limit, with all-ones data in the width register.
        // The records end early, but the run-length one first yields a full 128-pixel repeat.
        wait_drained();
        configure(32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF);
        put_header(MODE_RAW, 32'hFFFF, 32'hFFFF, 64'hFFFE_0001);
        put_random(2);
        send_record();
        put_header(MODE_RLE, 32'hFFFF, 32'hFFFF, 64'hFFFE_0001);
        put_byte(8'hFF);
        put_byte(8'h00);
        send_record();

        // Random part. The first phase starts under the long receiver stall, which
        // fills the queue and backs up the input.
        wait_drained();
        configure(32'd8, 32'd8, 32'd64);
        hold_req    = 1'b1;
        phase_start = items_sent;
        while (items_sent < TARGET_ITEMS)
        begin
            if (items_sent >= QUIET_AFTER)
                quiet = 1'b1;
            random_record();
            if (items_sent - phase_start >= PHASE_ITEMS && items_sent < TARGET_ITEMS)
            begin
                wait_drained();
                random_config();
                phase_start = items_sent;
            end
        end

        // Every byte is in; wait for the last results, then a few more cycles
        // so that any surplus result would still be caught.
        wait_drained();
        if (err_count == 0 && pend_count == 0)
            $display("tb_alpha_run_length_record_decoder OK");
        else
            $display("tb_alpha_run_length_record_decoder NOT OK");
        $finish;
    end

    // Far beyond the slowest correct run.
    initial
    begin : watchdog
        #5_000_000;
        $display("tb_alpha_run_length_record_decoder NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/arlrd_pkg.sv
rtl/core/arlrd_if.sv
rtl/core/arlrd_front.sv
rtl/core/arlrd_queue.sv
rtl/core/arlrd_back.sv
rtl/core/alpha_run_length_record_decoder.sv
bench/arlrd_result_check.sv
bench/tb_alpha_run_length_record_decoder.sv
